[sv/wfms_pkg.sv]
// Shared types and constants for the windowed flow minimum smoother.
// Used by the top level and by its checker; depends on nothing else.
`default_nettype none

package wfms_pkg;

  localparam int REQ_W       = 2;
  localparam int CYL_W       = 4;
  localparam int ALPHA_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int LEN_FIELD_W = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [ALPHA_W:0]   ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'hFFFF;
  localparam logic [ALPHA_W-1:0] ROUND_HALF  = 16'h8000;

  typedef enum logic [REQ_W-1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_END    = 2'd2
  } req_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RING_LENGTH     = 1'b0,
    CFG_SMOOTHING_ALPHA = 1'b1
  } cfg_index_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_WRITE = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL_A = 8'b0001_0000,
    S_MUL_B = 8'b0010_0000,
    S_ROUND = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

[sv/windowed_flow_min_smoother.sv]
// Windowed flow minimum smoother: window averaging, ring minimum, smoother.
// Depends on wfms_pkg and wfms_divider.
// Start and sample words may follow back to back while the block is idle.
// An end word of a non-empty window runs the divider, one ring write, a scan
// of the ring over the memory port, then the smoothing and output steps.
// Synchronous reset is immediate; the ring reads as all ones until written.
`default_nettype none

module windowed_flow_min_smoother #(
  parameter int RING_DEPTH = 16,
  parameter int FLOW_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [wfms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [wfms_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [wfms_pkg::REQ_W-1:0]        req_type,
  input  wire logic [wfms_pkg::CYL_W-1:0]        cylinder,
  input  wire logic [FLOW_BITS-1:0]              flow_sample,
  input  wire logic                              sample_valid,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [wfms_pkg::CYL_W-1:0]             window_cylinder,
  output logic [FLOW_BITS-1:0]                   min_flow,
  output logic [FLOW_BITS-1:0]                   filtered_flow,
  output logic [COUNT_BITS-1:0]                  samples_used,
  output logic                                   status
);

  localparam int SUM_W  = FLOW_BITS + COUNT_BITS;
  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W  = $clog2(RING_DEPTH + 1);
  localparam int PROD_W = FLOW_BITS + wfms_pkg::ALPHA_W + 1;
  localparam int ACC_W  = PROD_W + 1;

  wfms_pkg::state_t state;

  logic [SUM_W-1:0]                    running_sum;
  logic [COUNT_BITS-1:0]               sample_count;
  logic                                window_open;
  logic [wfms_pkg::CYL_W-1:0]          open_cylinder;
  logic [IDX_W-1:0]                    ring_position;
  logic [LEN_W-1:0]                    ring_length;
  logic [wfms_pkg::ALPHA_W-1:0]        smoothing_alpha;
  logic [FLOW_BITS-1:0]                smoothed_value;
  logic                                smoother_loaded;
  logic [RING_DEPTH-1:0]               ring_valid;
  logic [FLOW_BITS-1:0]                ring_mem [RING_DEPTH];
  logic [FLOW_BITS-1:0]                rd_data;
  logic                                rd_ok;
  logic                                rd_pending;
  logic [LEN_W-1:0]                    scan_cnt;
  logic [FLOW_BITS-1:0]                min_val;
  logic [COUNT_BITS-1:0]               res_cnt;
  logic                                res_status;
  logic [ACC_W-1:0]                    acc;
  logic [PROD_W-1:0]                   mul_q;

  logic                                in_accept;
  logic                                div_start;
  logic                                div_done;
  logic [SUM_W-1:0]                    div_quo;
  logic [COUNT_BITS-1:0]               eff_count;
  logic [wfms_pkg::LEN_FIELD_W-1:0]    cfg_len_raw;
  logic [LEN_W-1:0]                    cfg_len;
  logic [IDX_W-1:0]                    pos_eff;
  logic [IDX_W-1:0]                    pos_next;
  logic                                mem_we;
  logic                                issue;
  logic [IDX_W-1:0]                    rd_addr;
  logic [FLOW_BITS-1:0]                rd_val;
  logic [FLOW_BITS-1:0]                mul_x;
  logic [wfms_pkg::ALPHA_W:0]          mul_y;
  logic [PROD_W-1:0]                   product;
  logic [ACC_W-1:0]                    acc_total;

  assign in_stall  = (state != wfms_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign eff_count = window_open ? sample_count : '0;
  assign div_start = in_accept && (req_type == wfms_pkg::REQ_END) && (eff_count != '0);
  assign mem_we    = (state == wfms_pkg::S_WRITE);
  assign issue     = (scan_cnt < ring_length);
  assign rd_addr   = scan_cnt[IDX_W-1:0];
  assign rd_val    = rd_ok ? rd_data : '1;

  always_comb begin
    cfg_len_raw = cfg_data[wfms_pkg::LEN_FIELD_W-1:0];
    if (cfg_len_raw == '0) begin
      cfg_len = LEN_W'(1);
    end else if (int'(cfg_len_raw) > RING_DEPTH) begin
      cfg_len = LEN_W'(RING_DEPTH);
    end else begin
      cfg_len = LEN_W'(cfg_len_raw);
    end
  end

  always_comb begin
    pos_eff = (LEN_W'(ring_position) >= ring_length) ? '0 : ring_position;
    if (LEN_W'(pos_eff) + LEN_W'(1) == ring_length) begin
      pos_next = '0;
    end else begin
      pos_next = pos_eff + IDX_W'(1);
    end
  end

  always_comb begin
    if (state == wfms_pkg::S_MUL_A) begin
      mul_x = smoothed_value;
      mul_y = wfms_pkg::ALPHA_ONE - {1'b0, smoothing_alpha};
    end else begin
      mul_x = min_val;
      mul_y = {1'b0, smoothing_alpha};
    end
    product   = PROD_W'(mul_x) * PROD_W'(mul_y);
    acc_total = acc + ACC_W'(mul_q) + ACC_W'(wfms_pkg::ROUND_HALF);
  end

  wfms_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[pos_eff] <= div_quo[FLOW_BITS-1:0];
    end
    rd_data <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= wfms_pkg::S_IDLE;
      running_sum     <= '0;
      sample_count    <= '0;
      window_open     <= 1'b0;
      open_cylinder   <= '0;
      ring_position   <= '0;
      ring_length     <= LEN_W'(1);
      smoothing_alpha <= wfms_pkg::ALPHA_RESET;
      smoothed_value  <= '0;
      smoother_loaded <= 1'b0;
      ring_valid      <= '0;
      rd_pending      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (wfms_pkg::cfg_index_t'(cfg_index))
          wfms_pkg::CFG_RING_LENGTH: begin
            ring_length   <= cfg_len;
            ring_valid    <= '0;
            ring_position <= '0;
          end
          wfms_pkg::CFG_SMOOTHING_ALPHA: begin
            smoothing_alpha <= cfg_data[wfms_pkg::ALPHA_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall && (state != wfms_pkg::S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        wfms_pkg::S_IDLE: begin
          if (in_accept) begin
            unique case (wfms_pkg::req_t'(req_type))
              wfms_pkg::REQ_START: begin
                running_sum   <= '0;
                sample_count  <= '0;
                window_open   <= 1'b1;
                open_cylinder <= cylinder;
              end
              wfms_pkg::REQ_SAMPLE: begin
                if (window_open && sample_valid && !(&sample_count)) begin
                  running_sum  <= running_sum + SUM_W'(flow_sample);
                  sample_count <= sample_count + COUNT_BITS'(1);
                end
              end
              wfms_pkg::REQ_END: begin
                res_cnt      <= eff_count;
                window_open  <= 1'b0;
                running_sum  <= '0;
                sample_count <= '0;
                if (eff_count == '0) begin
                  res_status <= 1'b1;
                  min_val    <= '0;
                  state      <= wfms_pkg::S_OUT;
                end else begin
                  res_status <= 1'b0;
                  state      <= wfms_pkg::S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        wfms_pkg::S_DIV: begin
          if (div_done) begin
            state <= wfms_pkg::S_WRITE;
          end
        end
        wfms_pkg::S_WRITE: begin
          ring_valid[pos_eff] <= 1'b1;
          ring_position       <= pos_next;
          scan_cnt            <= '0;
          min_val             <= '1;
          rd_pending          <= 1'b0;
          state               <= wfms_pkg::S_SCAN;
        end
        wfms_pkg::S_SCAN: begin
          rd_pending <= issue;
          if (issue) begin
            rd_ok    <= ring_valid[rd_addr];
            scan_cnt <= scan_cnt + LEN_W'(1);
          end
          if (rd_pending && (rd_val < min_val)) begin
            min_val <= rd_val;
          end
          if (!issue && !rd_pending) begin
            if (!smoother_loaded) begin
              smoothed_value  <= min_val;
              smoother_loaded <= 1'b1;
              state           <= wfms_pkg::S_OUT;
            end else begin
              state <= wfms_pkg::S_MUL_A;
            end
          end
        end
        wfms_pkg::S_MUL_A: begin
          acc   <= ACC_W'(product);
          state <= wfms_pkg::S_MUL_B;
        end
        wfms_pkg::S_MUL_B: begin
          mul_q <= product;
          state <= wfms_pkg::S_ROUND;
        end
        wfms_pkg::S_ROUND: begin
          smoothed_value <= acc_total[wfms_pkg::ALPHA_W +: FLOW_BITS];
          state          <= wfms_pkg::S_OUT;
        end
        wfms_pkg::S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            window_cylinder <= open_cylinder;
            min_flow        <= min_val;
            filtered_flow   <= smoothed_value;
            samples_used    <= res_cnt;
            status          <= res_status;
            state           <= wfms_pkg::S_IDLE;
          end
        end
        default: begin
          state <= wfms_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/wfms_divider.sv]
// Restoring divider that retires one quotient bit per cycle.
// Standalone; instantiated by windowed_flow_min_smoother.
`default_nettype none

module wfms_divider #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvsr;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_diff;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem, quotient[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dvsr};
    ge       = (rem_sh >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
      cnt      <= CNT_W'(DIVIDEND_W);
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
      rem      <= ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      cnt      <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/wfms_checker.sv]
// Port-level checks for windowed_flow_min_smoother, bound to the top level.
// Depends on wfms_pkg.
`default_nettype none

module wfms_checker #(
  parameter int FLOW_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [wfms_pkg::REQ_W-1:0] req_type,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [FLOW_BITS-1:0]       min_flow,
  input wire logic [COUNT_BITS-1:0]      samples_used,
  input wire logic                       status
);

  // A result word that is held back stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // An empty window reports neither a minimum nor a sample count.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (min_flow == '0) && (samples_used == '0))
    else $error("empty window result carries data");

  // A valid result always averaged at least one sample.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> (samples_used != '0))
    else $error("valid result with zero samples");

  // Closing a window keeps the input side busy on the next cycle.
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == wfms_pkg::REQ_END) |=> in_stall)
    else $error("end word did not occupy the block");

endmodule

bind windowed_flow_min_smoother wfms_checker #(
  .FLOW_BITS  (FLOW_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_wfms_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .min_flow     (min_flow),
  .samples_used (samples_used),
  .status       (status)
);

`default_nettype wire
